@@ rtl/core/lss_pkg.sv @@
//------------------------------------------------------------------------------
// LED strip sweep sequencer package
// Shared types and constants for the intake queue and the frame engine.
//------------------------------------------------------------------------------
`default_nettype none

package lss_pkg;

    // Signed width for paint positions: covers 3*127 plus the center offset.
    localparam int POS_W = 11;

    localparam logic [7:0] HOLD_SWEEP   = 8'h20;
    localparam logic [7:0] HOLD_OUTWARD = 8'hA0;
    localparam logic [7:0] FADE_SWEEP   = 8'h08;
    localparam logic [7:0] FADE_IDLE    = 8'h01;
    localparam logic [7:0] FADE_NONE    = 8'h00;

    localparam logic [2:0] EFF_FADE    = 3'd0;
    localparam logic [2:0] EFF_LEFT    = 3'd1;
    localparam logic [2:0] EFF_RIGHT   = 3'd2;
    localparam logic [2:0] EFF_INWARD  = 3'd3;
    localparam logic [2:0] EFF_OUTWARD = 3'd4;

    // One queued request: effect select or animation tick.
    typedef struct packed {
        logic       is_sel;
        logic [2:0] effect;
    } t_cmd;

    // One byte painted during a tick.
    typedef struct packed {
        logic                    en;
        logic signed [POS_W-1:0] pos;
        logic [7:0]              val;
    } t_slot;

endpackage

`default_nettype wire

@@ rtl/core/lss_front.sv @@
//------------------------------------------------------------------------------
// LED strip sweep sequencer intake
// Accepts request words, classifies them and queues them for the frame engine.
//------------------------------------------------------------------------------
`default_nettype none

module lss_front
    import lss_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic       i_is_sel,
    input  wire logic [2:0] i_effect_sel,
    output t_cmd            o_cmd,
    output logic            o_cmd_valid,
    input  wire logic       i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{is_sel: i_is_sel, effect: i_effect_sel};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_cmd_pop);
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/lss_back.sv @@
//------------------------------------------------------------------------------
// LED strip sweep sequencer frame engine
// Advances the effect state, rewrites the frame memory and streams it out.
//------------------------------------------------------------------------------
`default_nettype none

module lss_back
    import lss_pkg::*;
#(
    parameter int PIXELS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic        i_cmd_valid,
    output logic             o_cmd_pop,
    input  wire logic [7:0]  i_color_blue,
    input  wire logic [7:0]  i_color_red,
    input  wire logic [7:0]  i_color_green,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_data,
    output logic             o_last
);

    localparam int FB    = PIXELS * 3;
    localparam int IDX_W = $clog2(FB);
    localparam int CNT_W = $clog2(FB + 1);
    localparam int ZC    = (FB - 3) / 2;
    localparam int HALF  = PIXELS / 2;
    localparam int PB0   = 3 * (PIXELS - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_FADE = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [2:0]         r_effect, n_effect;
    logic [6:0]         r_sweep, n_sweep;
    logic               r_holding, n_holding;
    logic [7:0]         r_hold_cnt, n_hold_cnt;
    logic               r_power, n_power;
    logic [7:0]         r_step, n_step;
    logic               r_any, n_any;
    t_slot              r_slot [6];
    t_slot              n_slot [6];
    logic [CNT_W-1:0]   r_rd_idx, n_rd_idx;
    logic               r_pend, n_pend;
    logic [IDX_W-1:0]   r_pidx, n_pidx;

    logic [7:0]         r_mem [FB];
    logic               r_vld [FB];
    logic [7:0]         r_mem_q;
    logic               r_vld_q;

    logic [14:0]        r_ob_data [2];
    logic               r_ob_last [2];
    logic               r_ob_wp;
    logic               r_ob_rp;
    logic [1:0]         r_ob_cnt;

    logic               w_rd_en;
    logic               w_we;
    logic [7:0]         w_wdata;
    logic               w_push;
    logic               w_pop;
    logic [14:0]        w_push_data;
    logic               w_push_last;

    function automatic t_slot mk_slot(input logic en,
                                      input logic signed [POS_W-1:0] pos,
                                      input logic [7:0] val);
        t_slot s;
        s.en  = en;
        s.pos = pos;
        s.val = val;
        return s;
    endfunction

    assign w_pop = o_valid && i_ready;

    always_comb begin
        logic signed [POS_W-1:0] sp;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] pb;
        logic signed [POS_W-1:0] zc;
        logic signed [POS_W-1:0] pidx_s;
        logic [6:0]              sweep_inc;
        logic [7:0]              hc_inc;
        logic                    en_a;
        logic                    en_b;
        logic [7:0]              cur;
        logic [7:0]              faded;
        logic [2:0]              occ;
        logic [IDX_W+5:0]        idx_ext;

        n_state    = r_state;
        n_effect   = r_effect;
        n_sweep    = r_sweep;
        n_holding  = r_holding;
        n_hold_cnt = r_hold_cnt;
        n_power    = r_power;
        n_step     = r_step;
        n_any      = r_any;
        n_slot     = r_slot;
        n_rd_idx   = r_rd_idx;
        n_pidx     = r_pidx;
        o_cmd_pop  = 1'b0;
        w_rd_en    = 1'b0;
        w_we       = 1'b0;
        w_push     = 1'b0;

        sp        = signed'(POS_W'(r_sweep));
        y         = (sp <<< 1) + sp;
        pb        = signed'(POS_W'(PB0)) - y;
        zc        = signed'(POS_W'(ZC));
        pidx_s    = signed'(POS_W'(r_pidx));
        sweep_inc = r_sweep + 7'd1;
        hc_inc    = r_hold_cnt + 8'd1;
        en_a      = 1'b0;
        en_b      = 1'b0;
        idx_ext   = {6'b0, r_pidx};

        // Paint, then fade, the byte whose read data is present now.
        cur = r_vld_q ? r_mem_q : 8'd0;
        for (int k = 0; k < 6; k++) begin
            if (r_slot[k].en && (r_slot[k].pos == pidx_s)) begin
                cur = r_slot[k].val;
            end
        end
        faded       = (cur > r_step) ? (cur - r_step) : 8'd0;
        w_wdata     = faded;
        w_push_data = {r_power, (r_vld_q ? r_mem_q : 8'd0), idx_ext[5:0]};
        w_push_last = (r_pidx == IDX_W'(FB - 1));
        occ         = {1'b0, r_ob_cnt} + 3'(r_pend) - 3'(w_pop);

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.is_sel) begin
                        n_effect = i_cmd.effect;
                    end else begin
                        for (int k = 0; k < 6; k++) begin
                            n_slot[k] = mk_slot(1'b0, '0, 8'd0);
                        end
                        n_rd_idx = '0;
                        n_any    = 1'b0;
                        n_state  = ST_FADE;
                        case (r_effect)
                            EFF_LEFT, EFF_RIGHT, EFF_INWARD: begin
                                n_power = 1'b1;
                                n_step  = FADE_SWEEP;
                                if (r_holding) begin
                                    if (hc_inc > HOLD_SWEEP) begin
                                        n_sweep    = 7'd0;
                                        n_holding  = 1'b0;
                                        n_hold_cnt = 8'd0;
                                        n_effect   = r_effect + 3'd1;
                                    end else begin
                                        n_hold_cnt = hc_inc;
                                    end
                                end else begin
                                    en_a = (r_effect != EFF_RIGHT);
                                    en_b = (r_effect != EFF_LEFT);
                                    n_slot[0] = mk_slot(en_a, y, i_color_blue);
                                    n_slot[1] = mk_slot(en_a, POS_W'(y + 1), i_color_red);
                                    n_slot[2] = mk_slot(en_a, POS_W'(y + 2), i_color_green);
                                    n_slot[3] = mk_slot(en_b, pb, i_color_blue);
                                    n_slot[4] = mk_slot(en_b, POS_W'(pb + 1), i_color_red);
                                    n_slot[5] = mk_slot(en_b, POS_W'(pb + 2), i_color_green);
                                    n_sweep   = sweep_inc;
                                    if (r_effect == EFF_INWARD) begin
                                        if (int'(sweep_inc) > HALF) begin
                                            n_holding = 1'b1;
                                        end
                                    end else if (int'(sweep_inc) >= PIXELS) begin
                                        n_holding = 1'b1;
                                    end
                                end
                            end
                            EFF_OUTWARD: begin
                                n_power = 1'b1;
                                n_step  = FADE_NONE;
                                if (r_holding) begin
                                    if (hc_inc > HOLD_OUTWARD) begin
                                        n_sweep    = 7'd0;
                                        n_holding  = 1'b0;
                                        n_hold_cnt = 8'd0;
                                        n_effect   = EFF_FADE;
                                    end else begin
                                        n_hold_cnt = hc_inc;
                                    end
                                end else begin
                                    n_slot[0] = mk_slot(1'b1, POS_W'(zc + y + 2), i_color_blue);
                                    n_slot[1] = mk_slot(1'b1, POS_W'(zc + y + 3), i_color_red);
                                    n_slot[2] = mk_slot(1'b1, POS_W'(zc + y + 4), i_color_green);
                                    n_slot[3] = mk_slot(1'b1, POS_W'(zc - y + 1), i_color_green);
                                    n_slot[4] = mk_slot(1'b1, zc - y, i_color_red);
                                    n_slot[5] = mk_slot(1'b1, POS_W'(zc - y - 1), i_color_blue);
                                    n_sweep   = sweep_inc;
                                    if (int'(sweep_inc) > HALF) begin
                                        n_holding = 1'b1;
                                    end
                                end
                            end
                            default: begin
                                n_step = FADE_IDLE;
                            end
                        endcase
                    end
                end
            end
            ST_FADE: begin
                w_rd_en = (r_rd_idx < CNT_W'(FB));
                if (w_rd_en) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                    n_pidx   = r_rd_idx[IDX_W-1:0];
                end
                if (r_pend) begin
                    w_we  = 1'b1;
                    n_any = r_any || (faded != 8'd0);
                    if (w_push_last) begin
                        // Drop power only after a full pass left every byte dark.
                        if ((r_step != FADE_NONE) && !n_any) begin
                            n_power = 1'b0;
                        end
                        n_rd_idx = '0;
                        n_state  = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                w_rd_en = (r_rd_idx < CNT_W'(FB)) && (occ <= 3'd1);
                if (w_rd_en) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                    n_pidx   = r_rd_idx[IDX_W-1:0];
                end
                w_push = r_pend;
                if ((r_rd_idx == CNT_W'(FB)) && !r_pend) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_pend = w_rd_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_effect   <= EFF_FADE;
            r_sweep    <= 7'd0;
            r_holding  <= 1'b0;
            r_hold_cnt <= 8'd0;
            r_power    <= 1'b0;
            r_pend     <= 1'b0;
            r_rd_idx   <= '0;
            r_any      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_effect   <= n_effect;
            r_sweep    <= n_sweep;
            r_holding  <= n_holding;
            r_hold_cnt <= n_hold_cnt;
            r_power    <= n_power;
            r_pend     <= n_pend;
            r_rd_idx   <= n_rd_idx;
            r_any      <= n_any;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        r_slot <= n_slot;
        r_pidx <= n_pidx;
    end

    // Frame memory: one read and one write port, registered read data.
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_mem_q <= r_mem[r_rd_idx[IDX_W-1:0]];
            r_vld_q <= r_vld[r_rd_idx[IDX_W-1:0]];
        end
        if (w_we) begin
            r_mem[r_pidx] <= w_wdata;
        end
    end

    // Entries never written read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < FB; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_we) begin
            r_vld[r_pidx] <= 1'b1;
        end
    end

    // Two-entry output buffer.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ob_data[r_ob_wp] <= w_push_data;
            r_ob_last[r_ob_wp] <= w_push_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_wp  <= 1'b0;
            r_ob_rp  <= 1'b0;
            r_ob_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_ob_wp <= ~r_ob_wp;
            end
            if (w_pop) begin
                r_ob_rp <= ~r_ob_rp;
            end
            r_ob_cnt <= r_ob_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    assign o_valid = (r_ob_cnt != 2'd0);
    assign o_data  = {1'b0, r_ob_data[r_ob_rp]};
    assign o_last  = r_ob_last[r_ob_rp];

endmodule

`default_nettype wire

@@ rtl/core/led_strip_sweep_effect_sequencer_top.sv @@
//------------------------------------------------------------------------------
// LED strip sweep effect sequencer
// Effect animation over an RGB byte frame, one full frame streamed per tick.
//------------------------------------------------------------------------------
// Usage:
//   Slave stream: one word per request. tuser = 0 is an animation tick,
//   tuser = 1 selects the effect held in tdata[2:0] and produces nothing.
//   Master stream: each tick yields PIXELS*3 words in byte order; tdata
//   carries byte index, byte value and the strip power enable, tlast marks
//   the final byte. APB registers 0..2 (blue, red, green) at byte addresses
//   0, 4, 8 set the painted color; write them only while the block is idle.
//   Timing: a two-word request queue sits in front of the frame engine. A
//   tick is decoded, then an update pass over the frame memory rewrites
//   every byte, then the frame is streamed out; the engine takes the next
//   request only after the whole frame has been read out of the memory.
//   A select only sets the effect. The emit rate is set by the single
//   frame memory read port.
//   Reset: frame reads as all zero, effect 0, power off, colors 255.
//   Stall: a two-word output buffer absorbs the read in flight; the engine
//   pauses reads until it drains, and requests keep queuing up to two.
//------------------------------------------------------------------------------
`default_nettype none

module led_strip_sweep_effect_sequencer_top
    import lss_pkg::*;
#(
    parameter int PIXELS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [2:0] effect_sel, [7:3] zero
    input  wire logic        s_axis_tuser,   // [0] req_type
    // master stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [5:0] byte_index, [13:6] byte_value,
                                             // [14] power_on, [15] zero
    output logic             m_axis_tlast,   // last
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [1:0] REG_BLUE  = 2'd0;
    localparam logic [1:0] REG_RED   = 2'd1;
    localparam logic [1:0] REG_GREEN = 2'd2;

    logic [7:0] r_color_blue;
    logic [7:0] r_color_red;
    logic [7:0] r_color_green;
    logic       w_cfg_wr;
    t_cmd       w_cmd;
    logic       w_cmd_valid;
    logic       w_cmd_pop;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    // Register write at the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_blue  <= 8'hFF;
            r_color_red   <= 8'hFF;
            r_color_green <= 8'hFF;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_BLUE:  r_color_blue  <= pwdata[7:0];
                REG_RED:   r_color_red   <= pwdata[7:0];
                REG_GREEN: r_color_green <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_BLUE:  prdata = {24'd0, r_color_blue};
            REG_RED:   prdata = {24'd0, r_color_red};
            REG_GREEN: prdata = {24'd0, r_color_green};
            default:   prdata = 32'd0;
        endcase
    end

    // Front: classify and queue requests.
    lss_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_is_sel     (s_axis_tuser),
        .i_effect_sel (s_axis_tdata[2:0]),
        .o_cmd        (w_cmd),
        .o_cmd_valid  (w_cmd_valid),
        .i_cmd_pop    (w_cmd_pop)
    );

    // Back: advance effect state, rewrite and stream the frame.
    lss_back #(
        .PIXELS (PIXELS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_cmd_valid   (w_cmd_valid),
        .o_cmd_pop     (w_cmd_pop),
        .i_color_blue  (r_color_blue),
        .i_color_red   (r_color_red),
        .i_color_green (r_color_green),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_data        (m_axis_tdata),
        .o_last        (m_axis_tlast)
    );

endmodule

`default_nettype wire

@@ rtl/core/lss_checker.sv @@
//------------------------------------------------------------------------------
// LED strip sweep sequencer port checker
// Watches the output stream for frame ordering and stall behavior.
//------------------------------------------------------------------------------
`default_nettype none

module lss_checker #(
    parameter int PIXELS = 16
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    localparam logic [5:0] LAST_IDX = 6'((PIXELS * 3 - 1) % 64);

    // Hold a stalled word.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output word changed");

    // The frame ends on its final byte position.
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[5:0] == LAST_IDX)
        else $error("tlast on wrong byte index");

    // Byte positions advance by one inside a frame.
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            !m_axis_tvalid || (m_axis_tdata[5:0] == $past(m_axis_tdata[5:0]) + 6'd1))
        else $error("byte index skipped inside frame");

    // Power enable is one value across a frame.
    a_power_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            !m_axis_tvalid || (m_axis_tdata[14] == $past(m_axis_tdata[14])))
        else $error("power enable changed inside frame");

endmodule

bind led_strip_sweep_effect_sequencer_top lss_checker #(.PIXELS(PIXELS)) u_lss_checker (.*);

`default_nettype wire
